>>> src/tcwnd_pkg.sv
package tcwnd_pkg;

   // Field and state widths
   localparam int SEQ_W = 16;
   localparam int WIN_W = 6;
   localparam int CMD_W = 2;
   localparam int KIND_W = 2;
   localparam int PHASE_W = 2;
   localparam int EXP_W = 3;
   localparam int DUP_W = 3;
   localparam int WIDE_W = 8;   // holds 2^7 and threshold + 3 before clamping

   // Window limits
   localparam int MAX_WINDOW = 32;
   localparam int CWND_CAP = (MAX_WINDOW < 63) ? MAX_WINDOW : 63;
   localparam int TX_CAP = 32;  // new packets per input word
   localparam int CNT_W = $clog2(TX_CAP + 1);

   localparam logic [WIN_W-1:0] THRESH_RESET = WIN_W'(8);
   localparam logic [DUP_W-1:0] DUP_SAT = DUP_W'(4);
   localparam logic [DUP_W-1:0] DUP_TRIGGER = DUP_W'(3);
   localparam logic [EXP_W-1:0] EXP_SAT = EXP_W'(7);

   // Request commands
   localparam logic [CMD_W-1:0] CMD_MESSAGE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ACK = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_NEW = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RETX = 2'd1;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

   // Congestion phases
   localparam logic [PHASE_W-1:0] PHASE_SLOW_START = 2'd0;
   localparam logic [PHASE_W-1:0] PHASE_AVOIDANCE = 2'd1;
   localparam logic [PHASE_W-1:0] PHASE_RECOVERY = 2'd2;

   typedef struct packed {
      logic capture;      // latch the request word
      logic execute;      // apply the state update
      logic emit_single;  // load the retransmit / release word
      logic emit_send;    // load one new-packet word
   } tcwnd_cmd_type;

   typedef struct packed {
      logic exec_single;  // update yields a retransmit or release word
      logic exec_send;    // update is followed by the send loop
      logic single_last;  // no new packet follows the single word
      logic send_ok;      // a new packet may go out now
      logic send_last;    // the packet going out now ends the loop
      logic out_free;     // output register can take a word
   } tcwnd_status_type;

   function automatic logic [WIN_W-1:0] clamp_window(input logic [WIDE_W-1:0] w);
      logic [WIN_W-1:0] r;
      if (w == '0) begin
         r = WIN_W'(1);
      end else if (w > WIDE_W'(CWND_CAP)) begin
         r = WIN_W'(CWND_CAP);
      end else begin
         r = w[WIN_W-1:0];
      end
      return r;
   endfunction

endpackage

>>> src/tcwnd_ctrl.sv
module tcwnd_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  tcwnd_pkg::tcwnd_status_type status,
   output tcwnd_pkg::tcwnd_cmd_type    cmd
);
   import tcwnd_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_SINGLE = 2'd2;
   localparam logic [1:0] ST_SEND = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            if (status.exec_single) begin
               state_in = ST_SINGLE;
            end else if (status.exec_send) begin
               state_in = ST_SEND;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SINGLE: begin
            if (status.out_free) begin
               cmd.emit_single = 1'b1;
               state_in = status.single_last ? ST_IDLE : ST_SEND;
            end
         end
         ST_SEND: begin
            if (!status.send_ok) begin
               state_in = ST_IDLE;
            end else if (status.out_free) begin
               cmd.emit_send = 1'b1;
               if (status.send_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> src/tcwnd_dpath.sv
module tcwnd_dpath (
   input  logic                               clock,
   input  logic                               reset,
   input  tcwnd_pkg::tcwnd_cmd_type           cmd,
   output tcwnd_pkg::tcwnd_status_type        status,
   input  logic                               csr_write_enable,
   input  logic [tcwnd_pkg::WIN_W-1:0]        csr_write_data,
   input  logic [tcwnd_pkg::CMD_W-1:0]        req_cmd,
   input  logic [tcwnd_pkg::SEQ_W-1:0]        req_ack_number,
   input  logic                               req_ack_intact,
   input  logic [tcwnd_pkg::SEQ_W-1:0]        req_expired_seq,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tcwnd_pkg::KIND_W-1:0]       rsp_kind,
   output logic [tcwnd_pkg::SEQ_W-1:0]        rsp_seq_number,
   output logic [tcwnd_pkg::SEQ_W-1:0]        rsp_release_end,
   output logic [tcwnd_pkg::WIN_W-1:0]        rsp_window_now,
   output logic                               rsp_last
);
   import tcwnd_pkg::*;

   // Latched request word
   logic [CMD_W-1:0]   in_cmd_ff;
   logic [SEQ_W-1:0]   in_ack_ff;
   logic               in_intact_ff;
   logic [SEQ_W-1:0]   in_expired_ff;

   // Congestion state
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [WIN_W-1:0]   cwnd_ff, cwnd_in;
   logic [WIN_W-1:0]   ssthresh_ff, ssthresh_in;
   logic [EXP_W-1:0]   gexp_ff, gexp_in;
   logic [DUP_W-1:0]   dup_ff, dup_in;
   logic [SEQ_W-1:0]   base_ff, base_in;
   logic [SEQ_W-1:0]   nts_ff, nts_in;
   logic [SEQ_W-1:0]   buffered_ff, buffered_in;

   // Per-word bookkeeping
   logic [CNT_W-1:0]   sent_ff, sent_in;
   logic               do_send_ff, do_send_in;
   logic [KIND_W-1:0]  single_kind_ff, single_kind_in;
   logic [SEQ_W-1:0]   single_seq_ff, single_seq_in;
   logic [SEQ_W-1:0]   single_end_ff, single_end_in;

   // Output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]  rsp_kind_ff, rsp_kind_in;
   logic [SEQ_W-1:0]   rsp_seq_ff, rsp_seq_in;
   logic [SEQ_W-1:0]   rsp_end_ff, rsp_end_in;
   logic [WIN_W-1:0]   rsp_win_ff, rsp_win_in;
   logic               rsp_last_ff, rsp_last_in;

   // Send loop conditions
   logic [SEQ_W:0]     limit;
   logic [SEQ_W:0]     nts_p1;
   logic [CNT_W-1:0]   sent_p1;
   logic               send_ok;
   logic               send_last;
   logic               out_free;

   // Update helpers
   logic               is_dup;
   logic [DUP_W-1:0]   dup_n;
   logic [WIN_W-1:0]   half_cwnd;
   logic [WIN_W-1:0]   ss_cwnd;
   logic               exec_single;
   logic               exec_send;

   assign limit = {1'b0, base_ff} + (SEQ_W+1)'(cwnd_ff);
   assign nts_p1 = {1'b0, nts_ff} + (SEQ_W+1)'(1);
   assign sent_p1 = sent_ff + CNT_W'(1);
   assign send_ok = ({1'b0, nts_ff} < limit) && (nts_ff < buffered_ff)
                    && (sent_ff < CNT_W'(TX_CAP));
   assign send_last = !((nts_p1 < limit) && (nts_p1 < {1'b0, buffered_ff})
                        && (sent_p1 < CNT_W'(TX_CAP)));
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign is_dup = (in_ack_ff <= base_ff);
   assign dup_n = (dup_ff < DUP_SAT) ? dup_ff + DUP_W'(1) : dup_ff;
   assign half_cwnd = cwnd_ff >> 1;
   assign ss_cwnd = clamp_window(WIDE_W'(1) << gexp_ff);

   always_comb begin
      phase_in = phase_ff;
      cwnd_in = cwnd_ff;
      ssthresh_in = ssthresh_ff;
      gexp_in = gexp_ff;
      dup_in = dup_ff;
      base_in = base_ff;
      nts_in = nts_ff;
      buffered_in = buffered_ff;
      sent_in = sent_ff;
      do_send_in = do_send_ff;
      single_kind_in = single_kind_ff;
      single_seq_in = single_seq_ff;
      single_end_in = single_end_ff;
      exec_single = 1'b0;
      exec_send = 1'b0;

      case (in_cmd_ff)
         CMD_MESSAGE: begin
            if (buffered_ff != '1) begin
               buffered_in = buffered_ff + SEQ_W'(1);
            end
            exec_send = 1'b1;
         end
         CMD_ACK: begin
            if (in_intact_ff && is_dup) begin
               dup_in = dup_n;
               if (dup_n == DUP_TRIGGER) begin
                  // third duplicate: fast retransmit, enter recovery
                  if (phase_ff == PHASE_SLOW_START) begin
                     gexp_in = '0;
                  end
                  phase_in = PHASE_RECOVERY;
                  ssthresh_in = half_cwnd;
                  cwnd_in = clamp_window(WIDE_W'(half_cwnd) + WIDE_W'(3));
                  single_kind_in = KIND_RETX;
                  single_seq_in = in_ack_ff;
                  single_end_in = '0;
                  exec_single = 1'b1;
               end else if (phase_ff == PHASE_RECOVERY) begin
                  cwnd_in = clamp_window(WIDE_W'(cwnd_ff) + WIDE_W'(1));
                  exec_send = 1'b1;
               end
            end else if (in_intact_ff && (in_ack_ff <= nts_ff)) begin
               // new ack: release [base, ack)
               single_kind_in = KIND_RELEASE;
               single_seq_in = base_ff;
               single_end_in = in_ack_ff;
               exec_single = 1'b1;
               base_in = in_ack_ff;
               dup_in = '0;
               if (phase_ff == PHASE_SLOW_START) begin
                  cwnd_in = ss_cwnd;
                  gexp_in = (gexp_ff != EXP_SAT) ? gexp_ff + EXP_W'(1) : gexp_ff;
                  if (ss_cwnd >= ssthresh_ff) begin
                     phase_in = PHASE_AVOIDANCE;
                     gexp_in = '0;
                  end
                  exec_send = 1'b1;
               end else if (phase_ff == PHASE_RECOVERY) begin
                  cwnd_in = clamp_window(WIDE_W'(ssthresh_ff));
                  phase_in = PHASE_AVOIDANCE;
               end else begin
                  cwnd_in = clamp_window(WIDE_W'(cwnd_ff) + WIDE_W'(1));
                  exec_send = 1'b1;
               end
            end
         end
         CMD_TIMEOUT: begin
            phase_in = PHASE_SLOW_START;
            ssthresh_in = half_cwnd;
            cwnd_in = WIN_W'(1);
            dup_in = '0;
            single_kind_in = KIND_RETX;
            single_seq_in = in_expired_ff;
            single_end_in = '0;
            exec_single = 1'b1;
         end
         default: begin
         end
      endcase

      if (cmd.execute) begin
         sent_in = '0;
         do_send_in = exec_send;
      end else begin
         // hold the congestion state outside the update cycle
         phase_in = phase_ff;
         cwnd_in = cwnd_ff;
         ssthresh_in = ssthresh_ff;
         gexp_in = gexp_ff;
         dup_in = dup_ff;
         base_in = base_ff;
         buffered_in = buffered_ff;
         single_kind_in = single_kind_ff;
         single_seq_in = single_seq_ff;
         single_end_in = single_end_ff;
      end

      if (cmd.emit_send) begin
         nts_in = nts_ff + SEQ_W'(1);
         sent_in = sent_p1;
      end

      if (csr_write_enable) begin
         ssthresh_in = csr_write_data;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_kind_in = rsp_kind_ff;
      rsp_seq_in = rsp_seq_ff;
      rsp_end_in = rsp_end_ff;
      rsp_win_in = rsp_win_ff;
      rsp_last_in = rsp_last_ff;
      if (cmd.emit_single) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in = single_kind_ff;
         rsp_seq_in = single_seq_ff;
         rsp_end_in = single_end_ff;
         rsp_win_in = cwnd_ff;
         rsp_last_in = !(do_send_ff && send_ok);
      end else if (cmd.emit_send) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in = KIND_NEW;
         rsp_seq_in = nts_ff;
         rsp_end_in = '0;
         rsp_win_in = cwnd_ff;
         rsp_last_in = send_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_SLOW_START;
         cwnd_ff <= WIN_W'(1);
         ssthresh_ff <= THRESH_RESET;
         gexp_ff <= EXP_W'(1);
         dup_ff <= '0;
         base_ff <= '0;
         nts_ff <= '0;
         buffered_ff <= '0;
         sent_ff <= '0;
         do_send_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         cwnd_ff <= cwnd_in;
         ssthresh_ff <= ssthresh_in;
         gexp_ff <= gexp_in;
         dup_ff <= dup_in;
         base_ff <= base_in;
         nts_ff <= nts_in;
         buffered_ff <= buffered_in;
         sent_ff <= sent_in;
         do_send_ff <= do_send_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_cmd_ff <= req_cmd;
         in_ack_ff <= req_ack_number;
         in_intact_ff <= req_ack_intact;
         in_expired_ff <= req_expired_seq;
      end
      single_kind_ff <= single_kind_in;
      single_seq_ff <= single_seq_in;
      single_end_ff <= single_end_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_seq_ff <= rsp_seq_in;
      rsp_end_ff <= rsp_end_in;
      rsp_win_ff <= rsp_win_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign status.exec_single = exec_single;
   assign status.exec_send = exec_send;
   assign status.single_last = !(do_send_ff && send_ok);
   assign status.send_ok = send_ok;
   assign status.send_last = send_last;
   assign status.out_free = out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_kind_ff;
   assign rsp_seq_number = rsp_seq_ff;
   assign rsp_release_end = rsp_end_ff;
   assign rsp_window_now = rsp_win_ff;
   assign rsp_last = rsp_last_ff;

   // base never passes the send pointer, which never passes the buffered count
   a_seq_order: assert property (@(posedge clock) disable iff (reset)
      (base_ff <= nts_ff) && (nts_ff <= buffered_ff))
      else $error("sequence pointers out of order");

   // a word is only loaded when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit_single || cmd.emit_send) |-> (!rsp_valid_ff || rsp_ready))
      else $error("output register overwritten");

   // new-packet count per request word stays within its cap, and each sent packet advances nts by one
   a_tx_cap: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_send |=> (sent_ff <= CNT_W'(TX_CAP)) && (nts_ff == $past(nts_ff) + SEQ_W'(1)))
      else $error("send loop exceeded cap");

endmodule

>>> src/tcp_sender_congestion_window.sv
// TCP Reno style sender window engine. Each request word is an application message,
// an acknowledgement or a retransmit timeout; the block updates slow start /
// congestion avoidance / fast recovery state and answers with zero or more response
// words (new packet, retransmit, or release of an acked range), the final one
// flagged by rsp_last. One request is handled at a time: req_ready is high only
// when the engine is idle. An item passes through request capture and the state
// update, then emits its response words (at most 33: one retransmit/release and 32 new
// packets); a send loop that ends without emitting anything still visits its check state;
// the rate is set by the single output register, which moves one word per cycle
// while rsp_ready is held high. Writing csr_write_data loads the slow start
// threshold directly (reset value 8); write it only while the block is idle.
module tcp_sender_congestion_window (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [tcwnd_pkg::WIN_W-1:0]   csr_write_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tcwnd_pkg::CMD_W-1:0]   req_cmd,
   input  logic [tcwnd_pkg::SEQ_W-1:0]   req_ack_number,
   input  logic                          req_ack_intact,
   input  logic [tcwnd_pkg::SEQ_W-1:0]   req_expired_seq,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [tcwnd_pkg::KIND_W-1:0]  rsp_kind,
   output logic [tcwnd_pkg::SEQ_W-1:0]   rsp_seq_number,
   output logic [tcwnd_pkg::SEQ_W-1:0]   rsp_release_end,
   output logic [tcwnd_pkg::WIN_W-1:0]   rsp_window_now,
   output logic                          rsp_last
);
   import tcwnd_pkg::*;

   tcwnd_cmd_type    cmd;
   tcwnd_status_type status;

   // sequencer: idle -> update -> single word -> send loop
   tcwnd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // window state, pointers and the output register
   tcwnd_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_cmd          (req_cmd),
      .req_ack_number   (req_ack_number),
      .req_ack_intact   (req_ack_intact),
      .req_expired_seq  (req_expired_seq),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_seq_number   (rsp_seq_number),
      .rsp_release_end  (rsp_release_end),
      .rsp_window_now   (rsp_window_now),
      .rsp_last         (rsp_last)
   );

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import tcwnd_pkg::*;

   // cmd value the block ignores; not part of the package
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   localparam int unsigned SEQ_MAX = (1 << SEQ_W) - 1;
   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 8;     // update + check cycles, with margin
   localparam int RANDOM_WORDS = 6;     // counted words per random phase
   localparam int LONG_HOLD = 400;      // receiver hold-off in cycles

   // One expected response word
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [SEQ_W-1:0]  seq_number;
      logic [SEQ_W-1:0]  release_end;
      logic [WIN_W-1:0]  window_now;
      logic              last;
   } tx_word_type;

   logic                clock;
   logic                reset;
   logic                csr_write_enable;
   logic [WIN_W-1:0]    csr_write_data;
   logic                req_valid;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd;
   logic [SEQ_W-1:0]    req_ack_number;
   logic                req_ack_intact;
   logic [SEQ_W-1:0]    req_expired_seq;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [KIND_W-1:0]   rsp_kind;
   logic [SEQ_W-1:0]    rsp_seq_number;
   logic [SEQ_W-1:0]    rsp_release_end;
   logic [WIN_W-1:0]    rsp_window_now;
   logic                rsp_last;

   tcp_sender_congestion_window u_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_cmd          (req_cmd),
      .req_ack_number   (req_ack_number),
      .req_ack_intact   (req_ack_intact),
      .req_expired_seq  (req_expired_seq),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_seq_number   (rsp_seq_number),
      .rsp_release_end  (rsp_release_end),
      .rsp_window_now   (rsp_window_now),
      .rsp_last         (rsp_last)
   );

   // Response words still owed by the block, oldest first
   tx_word_type pending_words[$];
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned send_idle_pct = 0;    // chance of a gap before each request word
   int unsigned rsp_stall_pct = 0;    // chance of rsp_ready low per cycle
   int unsigned rsp_hold_cycles = 0;  // long hold-off, run down by the receiver
   bit          last_acted;           // last accepted word changed the state

   // Shadow congestion state
   logic [PHASE_W-1:0] cc_phase;
   int unsigned cc_cwnd;
   int unsigned cc_ssthresh;
   int unsigned cc_init_thresh;
   int unsigned cc_exp;
   int unsigned cc_dups;
   int unsigned cc_base;
   int unsigned cc_next;
   int unsigned cc_buffered;

   // ------------------------------------------------------------------
   // Clock, watchdog
   // ------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic int unsigned window_limit(int unsigned w);
      if (w < 1) return 1;
      if (w > CWND_CAP) return CWND_CAP;
      return w;
   endfunction

   // Send loop: new packets while inside the window and buffered
   function automatic void push_new_packets(ref tx_word_type words[$]);
      tx_word_type w;
      int unsigned sent;
      sent = 0;
      w = '{default: '0};
      while (cc_next < cc_base + cc_cwnd && cc_next < cc_buffered && sent < TX_CAP) begin
         w.kind = KIND_NEW;
         w.seq_number = SEQ_W'(cc_next);
         words = {words, w};
         sent++;
         cc_next++;
      end
   endfunction

   // Apply one accepted request word to the shadow state and queue its responses
   function automatic void predict_window(input logic [CMD_W-1:0] cmd,
                                          input logic [SEQ_W-1:0] ack,
                                          input logic             intact,
                                          input logic [SEQ_W-1:0] expired);
      tx_word_type words[$];
      tx_word_type w;
      w = '{default: '0};
      last_acted = 1'b1;
      case (cmd)
         CMD_MESSAGE: begin
            if (cc_buffered < SEQ_MAX) cc_buffered++;
            push_new_packets(words);
         end
         CMD_ACK: begin
            if (!intact) begin
               last_acted = 1'b0;
            end else if (ack <= cc_base) begin
               // duplicate
               if (cc_dups < DUP_SAT) cc_dups++;
               if (cc_dups == DUP_TRIGGER) begin
                  if (cc_phase == PHASE_SLOW_START) cc_exp = 0;
                  cc_phase = PHASE_RECOVERY;
                  cc_ssthresh = (cc_cwnd >> 1) & 63;
                  cc_cwnd = window_limit(cc_ssthresh + 3);
                  w.kind = KIND_RETX;
                  w.seq_number = ack;
                  words = {words, w};
               end else if (cc_phase == PHASE_RECOVERY) begin
                  cc_cwnd = window_limit(cc_cwnd + 1);
                  push_new_packets(words);
               end
            end else if (ack > cc_next) begin
               last_acted = 1'b0;
            end else begin
               // new ack: release first, then window update by phase
               w.kind = KIND_RELEASE;
               w.seq_number = SEQ_W'(cc_base);
               w.release_end = ack;
               words = {words, w};
               cc_base = ack;
               cc_dups = 0;
               if (cc_phase == PHASE_SLOW_START) begin
                  cc_cwnd = window_limit(1 << (cc_exp & 7));
                  if (cc_exp < EXP_SAT) cc_exp++;
                  if (cc_cwnd >= cc_ssthresh) begin
                     cc_phase = PHASE_AVOIDANCE;
                     cc_exp = 0;
                  end
                  push_new_packets(words);
               end else if (cc_phase == PHASE_RECOVERY) begin
                  cc_cwnd = window_limit(cc_ssthresh);
                  cc_phase = PHASE_AVOIDANCE;
               end else begin
                  cc_cwnd = window_limit(cc_cwnd + 1);
                  push_new_packets(words);
               end
            end
         end
         CMD_TIMEOUT: begin
            cc_phase = PHASE_SLOW_START;
            cc_ssthresh = (cc_cwnd >> 1) & 63;
            cc_cwnd = 1;
            cc_dups = 0;
            w.kind = KIND_RETX;
            w.seq_number = expired;
            words = {words, w};
         end
         default: begin
            last_acted = 1'b0;
         end
      endcase
      foreach (words[i]) begin
         words[i].window_now = WIN_W'(cc_cwnd);
         words[i].last = (i == words.size() - 1);
         pending_words = {pending_words, words[i]};
      end
   endfunction

   // ------------------------------------------------------------------
   // Receiver: drives rsp_ready at the falling edge; long hold-off first
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold_cycles != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_cycles = rsp_hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Checker: each accepted response word against the oldest expectation
   always @(posedge clock) begin : check_rsp
      tx_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_words.size() == 0) begin
            $error("unexpected response word: kind %0d seq_number %0d",
                   rsp_kind, rsp_seq_number);
            fail_count++;
         end else begin
            want = pending_words.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_seq_number !== want.seq_number) begin
               $error("seq_number: expected %0d, actual %0d",
                      want.seq_number, rsp_seq_number);
               fail_count++;
            end
            if (rsp_release_end !== want.release_end) begin
               $error("release_end: expected %0d, actual %0d",
                      want.release_end, rsp_release_end);
               fail_count++;
            end
            if (rsp_window_now !== want.window_now) begin
               $error("window_now: expected %0d, actual %0d",
                      want.window_now, rsp_window_now);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------
   // Offer one request word (after random gaps) and predict it on acceptance.
   // Entered after a rising edge; payload changes only at falling edges.
   task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [SEQ_W-1:0] ack,
                            input logic intact, input logic [SEQ_W-1:0] expired);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_ack_number  <= ack;
      req_ack_intact  <= intact;
      req_expired_seq <= expired;
      do @(posedge clock); while (!req_ready);
      predict_window(cmd, ack, intact, expired);
   endtask

   task automatic send_message();
      send_word(CMD_MESSAGE, SEQ_W'($urandom), 1'($urandom), SEQ_W'($urandom));
   endtask

   task automatic send_ack(input int unsigned ack, input logic intact);
      send_word(CMD_ACK, SEQ_W'(ack), intact, SEQ_W'($urandom));
   endtask

   task automatic send_timeout(input int unsigned expired);
      send_word(CMD_TIMEOUT, SEQ_W'($urandom), 1'($urandom), SEQ_W'(expired));
   endtask

   // Sender goes quiet until every expected word is in, then lets the
   // block finish any word that produced nothing
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Threshold register write, only with the block idle
   task automatic write_threshold(input int unsigned value);
      wait_drained();
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= WIN_W'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      cc_init_thresh = value & 63;
      cc_ssthresh = cc_init_thresh;
   endtask

   task automatic set_idling(input int unsigned send_pct, input int unsigned stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   // Hand-picked walk through every phase and every ignored case, at reset threshold
   task automatic test_directed_cases();
      set_idling(0, 0);
      send_message();                 // first packet goes out at once
      repeat (4) send_message();      // window of 1 is full, these just buffer
      send_ack(1, 1'b1);              // slow start doubling
      send_ack(3, 1'b1);
      send_ack(SEQ_MAX, 1'b1);        // ack past next_to_send: dropped
      send_ack(cc_next, 1'b0);        // corrupt ack: dropped
      send_word(CMD_RESERVED, SEQ_W'(SEQ_MAX), 1'b1, SEQ_W'(SEQ_MAX));
      repeat (3) send_ack(cc_base, 1'b1);  // third duplicate: fast retransmit
      send_ack(0, 1'b1);              // further duplicate inflates the window
      send_ack(0, 1'b1);              // duplicate count saturated
      repeat (2) send_message();
      send_ack(cc_next, 1'b1);        // leaves fast recovery, no send loop
      send_message();
      send_ack(cc_next, 1'b1);        // congestion avoidance +1
      send_timeout(SEQ_MAX);
      send_timeout(0);                // threshold drops to zero
      repeat (2) send_message();
      send_ack(cc_next, 1'b1);
   endtask

   // Threshold at both ends: 1 gives an immediate switch to avoidance,
   // 32 lets slow start climb to the full window
   task automatic test_threshold_extremes();
      set_idling(7, 7);
      send_timeout(cc_base);
      write_threshold(1);
      send_message();
      send_ack(cc_next, 1'b1);
      send_timeout(cc_base);
      write_threshold(32);
      repeat (6) begin
         repeat (4) send_message();
         send_ack(cc_next, 1'b1);
      end
   endtask

   // Receiver holds off while the sender keeps offering words; the output
   // register fills and req_ready drops. Then a full-window release burst.
   task automatic test_output_backpressure();
      wait_drained();
      set_idling(0, 0);
      rsp_hold_cycles = LONG_HOLD;
      repeat (40) send_message();
      send_ack(cc_next, 1'b1);
      repeat (8) send_message();
      send_ack(cc_next, 1'b1);
   endtask

   // Mostly well-formed traffic driven off the shadow state, with some noise
   task automatic test_random_traffic();
      int unsigned      send_pct[4] = '{0, 65, 0, 7};
      int unsigned      stall_pct[4] = '{0, 0, 65, 7};
      int unsigned      thresh_val[4];
      int unsigned      pick;
      int unsigned      sel;
      int unsigned      done;
      logic [CMD_W-1:0] cmd;
      logic [SEQ_W-1:0] ack;
      logic [SEQ_W-1:0] expd;
      logic             intact;
      thresh_val[0] = 31;
      thresh_val[1] = $urandom_range(32, 1);
      thresh_val[2] = 8;
      thresh_val[3] = $urandom_range(32, 1);
      for (int ph = 0; ph < 4; ph++) begin
         write_threshold(thresh_val[ph]);
         set_idling(send_pct[ph], stall_pct[ph]);
         done = 0;
         while (done < RANDOM_WORDS) begin
            pick = $urandom_range(99);
            ack = SEQ_W'($urandom);
            expd = SEQ_W'($urandom);
            intact = 1'($urandom);
            if (pick < 42) begin
               cmd = CMD_MESSAGE;
            end else if (pick < 90) begin
               cmd = CMD_ACK;
               intact = 1'b1;
               sel = $urandom_range(99);
               if (sel < 50 && cc_next > cc_base) begin
                  ack = SEQ_W'($urandom_range(cc_next, cc_base + 1));
               end else if (sel < 85) begin
                  // duplicates, mostly at the base
                  ack = (sel % 4 == 0) ? SEQ_W'($urandom_range(cc_base, 0)) : SEQ_W'(cc_base);
               end else if (sel < 92) begin
                  if (cc_next < SEQ_MAX) ack = SEQ_W'($urandom_range(SEQ_MAX, cc_next + 1));
               end else begin
                  intact = 1'b0;
               end
            end else if (pick < 97) begin
               cmd = CMD_TIMEOUT;
               if ($urandom_range(1) == 1 && cc_next > cc_base)
                  expd = SEQ_W'($urandom_range(cc_next - 1, cc_base));
            end else begin
               cmd = CMD_RESERVED;
            end
            send_word(cmd, ack, intact, expd);
            if (last_acted) done++;
            // now and then the sender waits for the block to empty out
            if ($urandom_range(99) < 3) wait_drained();
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_cmd          = CMD_MESSAGE;
      req_ack_number   = '0;
      req_ack_intact   = 1'b0;
      req_expired_seq  = '0;
      rsp_ready        = 1'b0;

      cc_phase       = PHASE_SLOW_START;
      cc_init_thresh = THRESH_RESET;
      cc_ssthresh    = cc_init_thresh;
      cc_cwnd        = 1;
      cc_exp         = 1;
      cc_dups        = 0;
      cc_base        = 0;
      cc_next        = 0;
      cc_buffered    = 0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_cases();
      test_threshold_extremes();
      test_output_backpressure();
      test_random_traffic();

      wait_drained();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
src/tcwnd_pkg.sv
src/tcwnd_ctrl.sv
src/tcwnd_dpath.sv
src/tcp_sender_congestion_window.sv
tb/tb.sv
